[hw/rtl/ntoe_pkg.sv]
// shared types and constants for the neighbor table
`default_nettype none

package ntoe_pkg;

  // table geometry and field widths
  localparam int unsigned ENTRIES_DEF   = 8;
  localparam int unsigned ID_W          = 32;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned SLOT_W        = 3;
  localparam int unsigned OCNT_W        = 4;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned CFG_ADDR_W    = 3;

  // configuration register reset and register indexes
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd7200000;
  localparam logic [0:0]        REG_TIMEOUT   = 1'b0;

  // transaction function codes
  localparam logic FUNC_BEACON = 1'b0;
  localparam logic FUNC_EXPIRE = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

[hw/rtl/ntoe_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module ntoe_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/neighbor_table_oldest_evict_expire.sv]
// top level of the neighbor table with aging and oldest-entry eviction
//
//   channel | direction | handshake        | payload
//   in_     | input     | in_valid/ready   | func, node_id, now_time
//   out_    | output    | out_valid/ready  | stored_slot, was_present, evicted_oldest,
//           |           |                  | removed_count, entry_count
//   cfg     | input     | apb psel/penable | timeout_ticks at byte address 0
//
// one transaction at a time: accept, then one ram read per cycle over the valid
// entries through the single ram read port; a beacon that finds its id stops the
// scan early. reset clears the entry count and the control state, not the ram; the
// ram needs no clearing pass.
// a waiting result sits in the output register while the next item is accepted.
`default_nettype none

module neighbor_table_oldest_evict_expire #(
  parameter int unsigned ENTRIES = ntoe_pkg::ENTRIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_func,
  input  wire logic [ntoe_pkg::ID_W-1:0]         in_node_id,
  input  wire logic [ntoe_pkg::TIME_W-1:0]       in_now_time,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [ntoe_pkg::SLOT_W-1:0]       out_stored_slot,
  output logic                                   out_was_present,
  output logic                                   out_evicted_oldest,
  output logic      [ntoe_pkg::OCNT_W-1:0]       out_removed_count,
  output logic      [ntoe_pkg::OCNT_W-1:0]       out_entry_count,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ntoe_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [ntoe_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [ntoe_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                   pready
);

  import ntoe_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned ROW_W = ID_W + TIME_W;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);

  // control state
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [TIME_W-1:0]  timeout_r;
  logic [CNT_W-1:0]   rd_cnt_r;
  logic               dv_r;
  logic               out_valid_r;

  // item and scan payload
  logic               func_r;
  logic [ID_W-1:0]    id_r;
  logic [TIME_W-1:0]  now_r;
  logic [IDX_W-1:0]   didx_r;
  logic [TIME_W-1:0]  best_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [CNT_W-1:0]   kept_r;
  logic [IDX_W-1:0]   res_slot_r;
  logic               res_present_r;
  logic               res_evicted_r;
  logic [CNT_W-1:0]   res_removed_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic               out_present_r;
  logic               out_evicted_r;
  logic [OCNT_W-1:0]  out_removed_r;
  logic [OCNT_W-1:0]  out_count_r;

  // ram ports
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ROW_W-1:0]   mem_wdata;
  logic [ROW_W-1:0]   mem_rdata;
  logic [ID_W-1:0]    rd_id;
  logic [TIME_W-1:0]  rd_seen;

  // scan decode
  logic               accept;
  logic               issue;
  logic               scan_last;
  logic               match;
  logic               scan_done;
  logic               take_min;
  logic [IDX_W-1:0]   min_idx;
  logic [TIME_W-1:0]  age;
  logic               keep;
  logic [CNT_W-1:0]   kept_nxt;
  logic [IDX_W-1:0]   pick;
  logic               has_room;
  logic               out_free;
  logic               cfg_wr;

  // entry row: id in the upper half, last-seen time in the lower half
  ntoe_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_cnt_r[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  assign rd_id   = mem_rdata[ROW_W-1:TIME_W];
  assign rd_seen = mem_rdata[TIME_W-1:0];

  // handshakes
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // scan bookkeeping on the row returned this cycle
  assign issue     = (state_r == ST_SCAN) && (rd_cnt_r < count_r) && !scan_done;
  assign scan_last = dv_r && (CNT_W'(didx_r) == count_r - CNT_W'(1));
  assign match     = dv_r && (func_r == FUNC_BEACON) && (rd_id == id_r);
  assign scan_done = (state_r == ST_SCAN) &&
                     ((count_r == '0) || match || scan_last);

  // running minimum of raw last-seen times, lowest index wins ties
  assign take_min = dv_r && ((didx_r == '0) || (rd_seen < best_r));
  assign min_idx  = take_min ? didx_r : best_idx_r;

  // wrap-around age test for expire
  assign age      = now_r - rd_seen;
  assign keep     = dv_r && (func_r == FUNC_EXPIRE) && (age <= timeout_r);
  assign kept_nxt = kept_r + CNT_W'(keep);

  // beacon slot choice: hit, append, or evict the oldest
  assign has_room = (count_r < FULL);
  always_comb begin
    if (match) begin
      pick = didx_r;
    end else if (has_room) begin
      pick = count_r[IDX_W-1:0];
    end else begin
      pick = min_idx;
    end
  end

  // ram write: beacon writes once at scan end, expire compacts survivors
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = kept_r[IDX_W-1:0];
    mem_wdata = mem_rdata;
    if (func_r == FUNC_BEACON) begin
      mem_we    = scan_done;
      mem_waddr = pick;
      mem_wdata = {id_r, now_r};
    end else begin
      mem_we    = keep && (state_r == ST_SCAN);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      timeout_r   <= TIMEOUT_RESET;
      rd_cnt_r    <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dv_r    <= issue;
      if (accept) begin
        rd_cnt_r <= '0;
      end else if (issue) begin
        rd_cnt_r <= rd_cnt_r + CNT_W'(1);
      end
      if (scan_done) begin
        if (func_r == FUNC_EXPIRE) begin
          count_r <= kept_nxt;
        end else if (!match && has_room) begin
          count_r <= count_r + CNT_W'(1);
        end
      end
      if (cfg_wr) begin
        timeout_r <= pwdata;
      end
      if ((state_r == ST_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      id_r   <= in_node_id;
      now_r  <= in_now_time;
      kept_r <= '0;
    end else if (state_r == ST_SCAN) begin
      kept_r <= kept_nxt;
    end
    if (issue) begin
      didx_r <= rd_cnt_r[IDX_W-1:0];
    end
    if (take_min && (state_r == ST_SCAN)) begin
      best_r     <= rd_seen;
      best_idx_r <= didx_r;
    end
    if (scan_done) begin
      if (func_r == FUNC_BEACON) begin
        res_slot_r    <= pick;
        res_present_r <= match;
        res_evicted_r <= !match && !has_room;
        res_removed_r <= '0;
      end else begin
        res_slot_r    <= '0;
        res_present_r <= 1'b0;
        res_evicted_r <= 1'b0;
        res_removed_r <= count_r - kept_nxt;
      end
    end
    if ((state_r == ST_FINISH) && out_free) begin
      out_slot_r    <= SLOT_W'(res_slot_r);
      out_present_r <= res_present_r;
      out_evicted_r <= res_evicted_r;
      out_removed_r <= OCNT_W'(res_removed_r);
      out_count_r   <= OCNT_W'(count_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_stored_slot    = out_slot_r;
  assign out_was_present    = out_present_r;
  assign out_evicted_oldest = out_evicted_r;
  assign out_removed_count  = out_removed_r;
  assign out_entry_count    = out_count_r;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[CFG_ADDR_W-1:2] == REG_TIMEOUT);
  assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_TIMEOUT) ? timeout_r : '0;

endmodule

`default_nettype wire

[hw/rtl/ntoe_checker.sv]
// port-level checks for the neighbor table, bound to the top level
`default_nettype none

module ntoe_checker #(
  parameter int unsigned ENTRIES = ntoe_pkg::ENTRIES_DEF
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [ntoe_pkg::SLOT_W-1:0] out_stored_slot,
  input wire logic                        out_was_present,
  input wire logic                        out_evicted_oldest,
  input wire logic [ntoe_pkg::OCNT_W-1:0] out_removed_count,
  input wire logic [ntoe_pkg::OCNT_W-1:0] out_entry_count
);

  import ntoe_pkg::*;

  localparam logic [OCNT_W-1:0] FULL_CNT = OCNT_W'(ENTRIES);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_stored_slot) &&
      $stable(out_entry_count) && $stable(out_removed_count))
    else $error("stalled result changed");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_was_present && out_evicted_oldest))
    else $error("hit and eviction together");

  // an expire that removed entries reports no beacon fields
  a_expire_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_removed_count != '0) |->
      (out_stored_slot == '0) && !out_was_present && !out_evicted_oldest)
    else $error("expire result carries beacon fields");

  // eviction only happens on a full table
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted_oldest |-> (out_entry_count == FULL_CNT))
    else $error("eviction on a table that is not full");

endmodule

bind neighbor_table_oldest_evict_expire ntoe_checker #(
  .ENTRIES (ENTRIES)
) u_ntoe_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_stored_slot    (out_stored_slot),
  .out_was_present    (out_was_present),
  .out_evicted_oldest (out_evicted_oldest),
  .out_removed_count  (out_removed_count),
  .out_entry_count    (out_entry_count)
);

`default_nettype wire
